// ===== src/srk_pkg.sv =====
// ----------------------------------------------------------------------------
// Smallest range package
// Shared constants, types and the heap entry ordering function.
// ----------------------------------------------------------------------------
`default_nettype none
package srk_pkg;
    localparam int MAX_LISTS  = 16;
    localparam int MAX_LENGTH = 64;
    localparam int LIST_W     = $clog2(MAX_LISTS);
    localparam int POS_W      = $clog2(MAX_LENGTH);
    localparam int ADDR_W     = LIST_W + POS_W;
    localparam int DEPTH      = MAX_LISTS * MAX_LENGTH;
    localparam int K_W        = 5;
    localparam int N_W        = 7;
    localparam int CNT_W      = 11;
    localparam int HCNT_W     = LIST_W + 1;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [32:0] WIDTH_ONES = '1;

    localparam logic CFG_LIST_COUNT  = 1'b0;
    localparam logic CFG_LIST_LENGTH = 1'b1;

    typedef struct packed {
        logic signed [31:0] value;
        logic [LIST_W-1:0]  lst;
        logic [POS_W-1:0]   pos;
    } heap_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_SCAN,
        ST_POP,
        ST_NEXT,
        ST_OUT
    } state_t;

    function automatic logic [31+LIST_W+POS_W:0] entry_key(input heap_entry_t e);
        return {~e.value[31], e.value[30:0], e.lst, e.pos};
    endfunction
endpackage
`default_nettype wire

// ===== src/smallest_range_k_sorted_lists.sv =====
// ----------------------------------------------------------------------------
// Smallest range covering k sorted lists
// Loads k sorted lists and searches the narrowest range holding one element
// of each list.
// ----------------------------------------------------------------------------
// Elements are accepted one per cycle while loading and written to a 1024-entry
// store. The transfer that completes k*n elements starts the search: seeding
// reads and writes each list's head (ST_SEED_RD, ST_SEED_WR), and each removal
// of the minimum takes a linear scan of the heap (one entry per cycle through a
// single comparator), then ST_POP and, but for the last removal, ST_NEXT. No
// element is accepted during the search. The result then moves into an output
// register and loading of the next set goes on while it waits; the block only
// stalls when a later search ends before the earlier result is taken.
`default_nettype none
module smallest_range_k_sorted_lists (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // value [31:0], list_index [35:32], position [41:36], zeros [47:42]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // range_low [31:0], range_high [63:32]
    output logic      [63:0] m_axis_tdata
);
    import srk_pkg::*;

    state_t              state_reg, state_next;
    logic [K_W-1:0]      list_count_reg;
    logic [N_W-1:0]      list_length_reg;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [HCNT_W-1:0]   hcount_reg, hcount_next;
    logic [LIST_W-1:0]   idx_reg, idx_next;
    logic [LIST_W-1:0]   min_idx_reg, min_idx_next;
    heap_entry_t         min_reg, min_next;
    logic signed [31:0]  max_reg, max_next;
    logic [32:0]         bwidth_reg, bwidth_next;
    logic [31:0]         blow_reg, blow_next, bhigh_reg, bhigh_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_low_reg, out_low_next, out_high_reg, out_high_next;
    heap_entry_t         heap [MAX_LISTS];

    logic [K_W-1:0]      k;
    logic [N_W-1:0]      n;
    logic [CNT_W-1:0]    total;
    logic signed [31:0]  in_value;
    logic [LIST_W-1:0]   in_lst;
    logic [POS_W-1:0]    in_pos;
    logic                in_ok;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [31:0]         ram_rdata;
    logic                heap_we;
    logic [LIST_W-1:0]   heap_wa;
    heap_entry_t         heap_wd;
    heap_entry_t         cur;
    logic [LIST_W-1:0]   last_idx;
    logic [32:0]         width;
    logic [N_W-1:0]      pos_inc;

    assign in_value = s_axis_tdata[31:0];
    assign in_lst   = s_axis_tdata[32 +: LIST_W];
    assign in_pos   = s_axis_tdata[32 + LIST_W +: POS_W];

    always_comb
    begin
        if (list_count_reg == '0)
            k = K_W'(1);
        else if (list_count_reg > K_W'(MAX_LISTS))
            k = K_W'(MAX_LISTS);
        else
            k = list_count_reg;
        if (list_length_reg == '0)
            n = N_W'(1);
        else if (list_length_reg > N_W'(MAX_LENGTH))
            n = N_W'(MAX_LENGTH);
        else
            n = list_length_reg;
    end

    assign total    = CNT_W'(k * n);
    assign in_ok    = ({1'b0, in_lst} < k) && ({1'b0, in_pos} < n);
    assign cur      = heap[idx_reg];
    assign last_idx = LIST_W'(hcount_reg - HCNT_W'(1));
    assign width    = {max_reg[31], max_reg} - {min_reg.value[31], min_reg.value};
    assign pos_inc  = N_W'(min_reg.pos) + N_W'(1);

    srk_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_count_reg  <= K_W'(1);
            list_length_reg <= N_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIST_COUNT:  list_count_reg  <= cfg_data[K_W-1:0];
                CFG_LIST_LENGTH: list_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            loaded_reg    <= '0;
            hcount_reg    <= '0;
            idx_reg       <= '0;
            max_reg       <= INT_MIN;
            bwidth_reg    <= WIDTH_ONES;
            blow_reg      <= '0;
            bhigh_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_low_reg   <= '0;
            out_high_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            hcount_reg    <= hcount_next;
            idx_reg       <= idx_next;
            max_reg       <= max_next;
            bwidth_reg    <= bwidth_next;
            blow_reg      <= blow_next;
            bhigh_reg     <= bhigh_next;
            out_valid_reg <= out_valid_next;
            out_low_reg   <= out_low_next;
            out_high_reg  <= out_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
        if (heap_we)
        begin
            heap[heap_wa] <= heap_wd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        hcount_next    = hcount_reg;
        idx_next       = idx_reg;
        max_next       = max_reg;
        bwidth_next    = bwidth_reg;
        blow_next      = blow_reg;
        bhigh_next     = bhigh_reg;
        min_next       = min_reg;
        min_idx_next   = min_idx_reg;
        out_valid_next = out_valid_reg;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        ram_we         = 1'b0;
        ram_waddr      = {in_lst, in_pos};
        ram_raddr      = {idx_reg, POS_W'(0)};
        heap_we        = 1'b0;
        heap_wa        = idx_reg;
        heap_wd        = '{value: ram_rdata, lst: idx_reg, pos: '0};
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && in_ok)
                begin
                    ram_we      = 1'b1;
                    loaded_next = loaded_reg + CNT_W'(1);
                    if (loaded_next >= total)
                    begin
                        state_next  = ST_SEED_RD;
                        idx_next    = '0;
                        hcount_next = '0;
                        max_next    = INT_MIN;
                        bwidth_next = WIDTH_ONES;
                    end
                end
            end
            ST_SEED_RD:
            begin
                state_next = ST_SEED_WR;
            end
            ST_SEED_WR:
            begin
                heap_we     = 1'b1;
                hcount_next = hcount_reg + HCNT_W'(1);
                if ($signed(ram_rdata) > max_reg)
                    max_next = ram_rdata;
                if ({1'b0, idx_reg} == k - K_W'(1))
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_SEED_RD;
                    idx_next   = idx_reg + LIST_W'(1);
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == '0 || entry_key(cur) < entry_key(min_reg))
                begin
                    min_next     = cur;
                    min_idx_next = idx_reg;
                end
                if (idx_reg == last_idx)
                    state_next = ST_POP;
                else
                    idx_next = idx_reg + LIST_W'(1);
            end
            ST_POP:
            begin
                if (width < bwidth_reg)
                begin
                    bwidth_next = width;
                    blow_next   = min_reg.value;
                    bhigh_next  = max_reg;
                end
                heap_we     = 1'b1;
                heap_wa     = min_idx_reg;
                heap_wd     = heap[last_idx];
                hcount_next = hcount_reg - HCNT_W'(1);
                ram_raddr   = {min_reg.lst, pos_inc[POS_W-1:0]};
                if (pos_inc < n)
                    state_next = ST_NEXT;
                else
                    state_next = ST_OUT;
            end
            ST_NEXT:
            begin
                heap_we     = 1'b1;
                heap_wa     = hcount_reg[LIST_W-1:0];
                heap_wd     = '{value: ram_rdata, lst: min_reg.lst,
                                pos: min_reg.pos + POS_W'(1)};
                hcount_next = hcount_reg + HCNT_W'(1);
                if ($signed(ram_rdata) > max_reg)
                    max_next = ram_rdata;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_low_next   = blow_reg;
                    out_high_next  = bhigh_reg;
                    state_next     = ST_LOAD;
                    loaded_next    = '0;
                    hcount_next    = '0;
                    max_next       = INT_MIN;
                    bwidth_next    = WIDTH_ONES;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_high_reg, out_low_reg};

`ifndef SYNTH
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcount_reg <= HCNT_W'(MAX_LISTS))
        else $error("heap count exceeds capacity");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result changed before its transfer");
    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && state_next == ST_LOAD)
        |=> (loaded_reg == '0 && hcount_reg == '0))
        else $error("counters not cleared after the search");
`endif
endmodule
`default_nettype wire

// ===== src/srk_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module srk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
